### hdl/nw_pkg.sv
// Shared widths, constants, register codes and the Taylor stage state type
// for the normalized window generator. No dependencies.
`default_nettype none

package nw_pkg;

  localparam int IDX_W     = 15;
  localparam int LEN_W     = 16;
  localparam int OIDX_W    = 31;
  localparam int AMP_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PH_W      = 32;
  localparam int PH_CELLS  = 32;
  localparam int TAYLOR_N  = 7;
  localparam int COS_LAT   = 2 + 3 * TAYLOR_N;
  localparam int TERM_W    = 31;
  localparam int X2_W      = 32;
  localparam int SUM_W     = 33;
  localparam int C_W       = 32;
  localparam int WIN_W     = 37;
  localparam int NUM_W     = WIN_W + AMP_W - 1;
  localparam int AMP_CELLS = 17;
  localparam int TAG_DEPTH = 1 + PH_CELLS + COS_LAT + 2 + AMP_CELLS;

  localparam logic [LEN_W-1:0] MAX_LENGTH = 16'd32768;
  localparam logic [LEN_W-1:0] RST_LENGTH = 16'd512;
  localparam logic [AMP_W-1:0] AMP_ONE    = 16'd32768;
  localparam logic [TERM_W-1:0] Q30_ONE   = 31'h4000_0000;
  // 2*pi in Q30 minus 2^32
  localparam logic [31:0] TWO_PI_FRAC     = 32'd2451551556;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET  = 2'd2;

  typedef struct packed {
    logic [X2_W-1:0]          x2;
    logic [TERM_W-1:0]        term;
    logic signed [SUM_W-1:0]  sum;
    logic                     neg;
  } nw_tstate_t;

  // divisor (2k-1)*2k for Taylor term k = idx+1
  function automatic logic [7:0] taylor_div(input logic [2:0] idx);
    logic [7:0] d;
    unique case (idx)
      3'd0: d = 8'd2;
      3'd1: d = 8'd12;
      3'd2: d = 8'd30;
      3'd3: d = 8'd56;
      3'd4: d = 8'd90;
      3'd5: d = 8'd132;
      3'd6: d = 8'd182;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] taylor_recip(input logic [2:0] idx);
    logic [31:0] m;
    unique case (idx)
      3'd0: m = 32'd2147483648;
      3'd1: m = 32'd357913941;
      3'd2: m = 32'd143165576;
      3'd3: m = 32'd76695844;
      3'd4: m = 32'd47721858;
      3'd5: m = 32'd32537631;
      3'd6: m = 32'd23598721;
      default: m = 32'd2147483648;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### hdl/normalized_window_generator.sv
// Top level of the normalized Hann/Hamming window generator.
// Depends on nw_pkg, nw_phase_cell, nw_cos, nw_taylor_cell, nw_amp_cell.
//
//   channel  dir  handshake               payload
//   in       in   in_valid / in_ready     sample_index
//   out      out  out_valid / out_ready   output_index, amplitude, range_error
//   cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per clock while the output is not stalled.
// The pipe runs through the 32-cell phase divider, 7 Taylor cells of 3 stages
// per lane, and the 17-cell amplitude divider; sample and peak run in two lanes.
// The whole pipe holds while out_valid is high and out_ready is low.
// Reset clears the valid line and loads register defaults; cfg_ready is always high.
`default_nettype none

module normalized_window_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [nw_pkg::IDX_W-1:0]         sample_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nw_pkg::OIDX_W-1:0]        output_index,
  output logic [nw_pkg::AMP_W-1:0]         amplitude,
  output logic                             range_error,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nw_pkg::LEN_W-1:0]         cfg_data
);

  localparam int D = nw_pkg::TAG_DEPTH;

  logic                         window_type;
  logic [nw_pkg::LEN_W-1:0]     window_length;
  logic [nw_pkg::LEN_W-1:0]     block_offset;
  logic [nw_pkg::LEN_W-1:0]     len_eff;
  logic                         adv;

  logic [D-1:0]                 tvld;
  logic [D-1:0]                 terr;
  logic [nw_pkg::OIDX_W-1:0]    toidx [D];
  logic [31:0]                  offs_prod;

  logic [nw_pkg::IDX_W-1:0]     idx_q;
  logic [nw_pkg::IDX_W-1:0]     pidx_q;
  logic [nw_pkg::IDX_W-1:0]     drem [nw_pkg::PH_CELLS+1];
  logic [nw_pkg::PH_W-1:0]      dquo [nw_pkg::PH_CELLS+1];
  logic [nw_pkg::IDX_W-1:0]     prem [nw_pkg::PH_CELLS+1];
  logic [nw_pkg::PH_W-1:0]      pquo [nw_pkg::PH_CELLS+1];

  logic signed [nw_pkg::C_W-1:0] c_d;
  logic signed [nw_pkg::C_W-1:0] c_p;
  logic signed [39:0]           a_s;
  logic signed [7:0]            b_s;
  logic signed [39:0]           wd_full;
  logic signed [39:0]           wp_full;
  logic [nw_pkg::WIN_W-1:0]     wd_q;
  logic [nw_pkg::WIN_W-1:0]     wp_q;
  logic [nw_pkg::NUM_W-1:0]     num;

  logic [nw_pkg::WIN_W-1:0]     awp  [nw_pkg::AMP_CELLS+1];
  logic [nw_pkg::WIN_W-1:0]     arem [nw_pkg::AMP_CELLS+1];
  logic [nw_pkg::AMP_CELLS-1:0] alow [nw_pkg::AMP_CELLS+1];
  logic [nw_pkg::AMP_CELLS-1:0] aquo [nw_pkg::AMP_CELLS+1];

  logic [nw_pkg::AMP_CELLS-1:0] qf;
  logic                         err_f;
  logic [nw_pkg::AMP_W-1:0]     amp_f;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign len_eff   = (window_length > nw_pkg::MAX_LENGTH) ? nw_pkg::MAX_LENGTH : window_length;
  assign offs_prod = block_offset * len_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_type   <= 1'b0;
      window_length <= nw_pkg::RST_LENGTH;
      block_offset  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nw_pkg::REG_WINDOW_TYPE:   window_type   <= cfg_data[0];
        nw_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data;
        nw_pkg::REG_BLOCK_OFFSET:  block_offset  <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid line and side data
  always_ff @(posedge clk) begin
    if (rst) begin
      tvld <= '0;
    end else if (adv) begin
      tvld <= {tvld[D-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_q    <= sample_index;
      pidx_q   <= len_eff[nw_pkg::LEN_W-1:1];
      terr[0]  <= {1'b0, sample_index} >= len_eff;
      toidx[0] <= offs_prod[nw_pkg::OIDX_W-1:0] + nw_pkg::OIDX_W'(sample_index);
      for (int i = 1; i < D; i++) begin
        terr[i]  <= terr[i-1];
        toidx[i] <= toidx[i-1];
      end
    end
  end

  // phase dividers, sample and peak lanes
  assign drem[0] = idx_q;
  assign dquo[0] = '0;
  assign prem[0] = pidx_q;
  assign pquo[0] = '0;

  for (genvar g = 0; g < nw_pkg::PH_CELLS; g++) begin : g_phase
    nw_phase_cell u_dcell (
      .clk(clk), .adv(adv), .len(len_eff),
      .rem_in(drem[g]), .quo_in(dquo[g]), .rem(drem[g+1]), .quo(dquo[g+1])
    );
    nw_phase_cell u_pcell (
      .clk(clk), .adv(adv), .len(len_eff),
      .rem_in(prem[g]), .quo_in(pquo[g]), .rem(prem[g+1]), .quo(pquo[g+1])
    );
  end

  nw_cos u_cos_d (.clk(clk), .adv(adv), .ph(dquo[nw_pkg::PH_CELLS]), .c(c_d));
  nw_cos u_cos_p (.clk(clk), .adv(adv), .ph(pquo[nw_pkg::PH_CELLS]), .c(c_p));

  // window value in units of 2^-30/100
  always_comb begin
    a_s     = (window_type ? 40'sd54 : 40'sd50) <<< 30;
    b_s     = window_type ? 8'sd46 : 8'sd50;
    wd_full = a_s - b_s * 40'(c_d);
    wp_full = a_s - b_s * 40'(c_p);
    num     = {wd_q, 15'b0} + nw_pkg::NUM_W'(wp_q >> 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wd_q    <= wd_full[nw_pkg::WIN_W-1:0];
      wp_q    <= wp_full[nw_pkg::WIN_W-1:0];
      awp[0]  <= wp_q;
      arem[0] <= nw_pkg::WIN_W'(num[nw_pkg::NUM_W-1:nw_pkg::AMP_CELLS]);
      alow[0] <= num[nw_pkg::AMP_CELLS-1:0];
    end
  end

  assign aquo[0] = '0;

  for (genvar g = 0; g < nw_pkg::AMP_CELLS; g++) begin : g_amp
    nw_amp_cell u_acell (
      .clk(clk), .adv(adv),
      .wp_in(awp[g]), .rem_in(arem[g]), .low_in(alow[g]), .quo_in(aquo[g]),
      .wp(awp[g+1]), .rem(arem[g+1]), .low(alow[g+1]), .quo(aquo[g+1])
    );
  end

  always_comb begin
    qf    = aquo[nw_pkg::AMP_CELLS];
    err_f = terr[D-1] || (awp[nw_pkg::AMP_CELLS] == '0);
    if (err_f) begin
      amp_f = '0;
    end else if (qf > nw_pkg::AMP_CELLS'(nw_pkg::AMP_ONE)) begin
      amp_f = nw_pkg::AMP_ONE;
    end else begin
      amp_f = qf[nw_pkg::AMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tvld[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      output_index <= toidx[D-1];
      amplitude    <= amp_f;
      range_error  <= err_f;
    end
  end

  a_err_zero_amp: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> amplitude == '0)
    else $error("flagged item carries nonzero amplitude");

  a_amp_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> amplitude <= nw_pkg::AMP_ONE)
    else $error("amplitude above 1.0");

  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(tvld))
    else $error("valid line moved while stalled");

endmodule

`default_nettype wire

### hdl/nw_phase_cell.sv
// One restoring-division step of the phase divider: one quotient bit per cell.
// Depends on nw_pkg.
`default_nettype none

module nw_phase_cell (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [nw_pkg::LEN_W-1:0]    len,
  input  logic [nw_pkg::IDX_W-1:0]    rem_in,
  input  logic [nw_pkg::PH_W-1:0]     quo_in,
  output logic [nw_pkg::IDX_W-1:0]    rem,
  output logic [nw_pkg::PH_W-1:0]     quo
);

  logic [nw_pkg::LEN_W-1:0] dbl;
  logic [nw_pkg::LEN_W-1:0] diff;
  logic                     ge;

  assign dbl  = {rem_in, 1'b0};
  assign ge   = dbl >= len;
  assign diff = dbl - len;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem <= ge ? diff[nw_pkg::IDX_W-1:0] : dbl[nw_pkg::IDX_W-1:0];
      quo <= {quo_in[nw_pkg::PH_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### hdl/nw_taylor_cell.sv
// One Taylor term of the cosine: multiply by x^2, divide by a constant via
// reciprocal and correction, accumulate. Three stages. Depends on nw_pkg.
`default_nettype none

module nw_taylor_cell (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [7:0]           div,
  input  logic [31:0]          recip,
  input  logic                 odd,
  input  nw_pkg::nw_tstate_t   st_in,
  output nw_pkg::nw_tstate_t   st
);

  nw_pkg::nw_tstate_t st_a;
  nw_pkg::nw_tstate_t st_b;
  logic [nw_pkg::TERM_W+nw_pkg::X2_W-1:0] prod_a;
  logic [31:0]                            v;
  logic [31:0]                            v_b;
  logic [63:0]                            pm_b;
  logic [31:0]                            q0;
  logic [31:0]                            r;
  logic [31:0]                            term_next;
  logic signed [nw_pkg::SUM_W-1:0]        term_s;
  logic signed [nw_pkg::SUM_W-1:0]        sum_next;

  assign v = prod_a[30+31:30];

  always_comb begin
    q0        = pm_b[63:32];
    r         = v_b - 32'(q0 * 32'(div));
    term_next = (r >= 32'(div)) ? q0 + 32'd1 : q0;
    term_s    = $signed({2'b00, term_next[nw_pkg::TERM_W-1:0]});
    sum_next  = odd ? st_b.sum - term_s : st_b.sum + term_s;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_a    <= st_in;
      prod_a  <= st_in.term * st_in.x2;
      st_b    <= st_a;
      v_b     <= v;
      pm_b    <= v * recip;
      st.x2   <= st_b.x2;
      st.term <= term_next[nw_pkg::TERM_W-1:0];
      st.sum  <= sum_next;
      st.neg  <= st_b.neg;
    end
  end

endmodule

`default_nettype wire

### hdl/nw_cos.sv
// Cosine of a Q32 phase in Q30: quadrant fold, angle scaling, square,
// then a chain of Taylor cells. Depends on nw_pkg, nw_taylor_cell.
`default_nettype none

module nw_cos (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [nw_pkg::PH_W-1:0]        ph,
  output logic signed [nw_pkg::C_W-1:0]  c
);

  logic [nw_pkg::PH_W-1:0]       fold;
  logic [nw_pkg::TERM_W-1:0]     t;
  logic                          neg;
  logic [nw_pkg::TERM_W-1:0]     t_f;
  logic                          neg_f;
  logic [62:0]                   pf;
  logic [nw_pkg::TERM_W-1:0]     theta;
  logic [61:0]                   sq_g;
  logic                          neg_g;
  logic [nw_pkg::TERM_W-1:0]     mag;
  logic signed [nw_pkg::C_W-1:0] mag_s;
  logic signed [nw_pkg::SUM_W-1:0] one_s;
  logic signed [nw_pkg::SUM_W-1:0] last_sum;
  nw_pkg::nw_tstate_t            st [nw_pkg::TAYLOR_N+1];

  always_comb begin
    fold = ph[nw_pkg::PH_W-1] ? (~ph + 32'd1) : ph;
    if (fold > 32'h4000_0000) begin
      t   = 31'(32'h8000_0000 - fold);
      neg = 1'b1;
    end else begin
      t   = fold[nw_pkg::TERM_W-1:0];
      neg = 1'b0;
    end
  end

  assign theta = t_f + pf[62:32];

  always_ff @(posedge clk) begin
    if (adv) begin
      t_f   <= t;
      neg_f <= neg;
      pf    <= t * nw_pkg::TWO_PI_FRAC;
      sq_g  <= theta * theta;
      neg_g <= neg_f;
    end
  end

  assign one_s = $signed(nw_pkg::SUM_W'(nw_pkg::Q30_ONE));

  always_comb begin
    st[0].x2   = sq_g[61:30];
    st[0].term = nw_pkg::Q30_ONE;
    st[0].sum  = one_s;
    st[0].neg  = neg_g;
  end

  for (genvar k = 0; k < nw_pkg::TAYLOR_N; k++) begin : g_term
    nw_taylor_cell u_cell (
      .clk   (clk),
      .adv   (adv),
      .div   (nw_pkg::taylor_div(3'(k))),
      .recip (nw_pkg::taylor_recip(3'(k))),
      .odd   (k % 2 == 0),
      .st_in (st[k]),
      .st    (st[k+1])
    );
  end

  assign last_sum = st[nw_pkg::TAYLOR_N].sum;

  always_comb begin
    if (last_sum < 0) begin
      mag = '0;
    end else if (last_sum > one_s) begin
      mag = nw_pkg::Q30_ONE;
    end else begin
      mag = last_sum[nw_pkg::TERM_W-1:0];
    end
    mag_s = $signed({1'b0, mag});
    c = st[nw_pkg::TAYLOR_N].neg ? -mag_s : mag_s;
  end

endmodule

`default_nettype wire

### hdl/nw_amp_cell.sv
// One restoring-division step of the amplitude divider (point over peak).
// Depends on nw_pkg.
`default_nettype none

module nw_amp_cell (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [nw_pkg::WIN_W-1:0]      wp_in,
  input  logic [nw_pkg::WIN_W-1:0]      rem_in,
  input  logic [nw_pkg::AMP_CELLS-1:0]  low_in,
  input  logic [nw_pkg::AMP_CELLS-1:0]  quo_in,
  output logic [nw_pkg::WIN_W-1:0]      wp,
  output logic [nw_pkg::WIN_W-1:0]      rem,
  output logic [nw_pkg::AMP_CELLS-1:0]  low,
  output logic [nw_pkg::AMP_CELLS-1:0]  quo
);

  logic [nw_pkg::WIN_W:0] dbl;
  logic [nw_pkg::WIN_W:0] diff;
  logic                   ge;

  assign dbl  = {rem_in, low_in[nw_pkg::AMP_CELLS-1]};
  assign ge   = dbl >= {1'b0, wp_in};
  assign diff = dbl - {1'b0, wp_in};

  always_ff @(posedge clk) begin
    if (adv) begin
      wp  <= wp_in;
      rem <= ge ? diff[nw_pkg::WIN_W-1:0] : dbl[nw_pkg::WIN_W-1:0];
      low <= {low_in[nw_pkg::AMP_CELLS-2:0], 1'b0};
      quo <= {quo_in[nw_pkg::AMP_CELLS-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for normalized_window_generator (Hann/Hamming points).
// Directed table plus random phases over many register settings, checked
// against an in-bench fixed-point predictor. Depends on nw_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [nw_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned PERIOD_HI = 6;
  localparam int unsigned PERIOD_LO = 6;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [nw_pkg::OIDX_W-1:0] oidx;
    logic [nw_pkg::AMP_W-1:0]  amp;
    logic                      err;
  } window_point_t;

  typedef struct {
    logic [nw_pkg::IDX_W-1:0] idx;
    bit                       known;
    logic [nw_pkg::AMP_W-1:0] amp;
    logic                     err;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [nw_pkg::IDX_W-1:0] sample_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [nw_pkg::OIDX_W-1:0] output_index;
  logic [nw_pkg::AMP_W-1:0] amplitude;
  logic range_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [nw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [nw_pkg::LEN_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  logic        win_hamming;
  logic [15:0] win_len;
  logic [15:0] blk_offset;

  window_point_t pending_points[$];
  int unsigned mismatches = 0;
  int unsigned points_checked = 0;
  int unsigned range_errors_seen = 0;
  int unsigned settings_used = 0;

  normalized_window_generator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample_index(sample_index),
    .out_valid(out_valid), .out_ready(out_ready), .output_index(output_index),
    .amplitude(amplitude), .range_error(range_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #PERIOD_HI clk = 1'b1;
    #PERIOD_LO clk = 1'b0;
  end

  initial begin
    #(64'd12 * 64'd3_000_000);
    $display("tb: failure");
    $finish;
  end

  // cosine of i/len turns, Q30
  function automatic longint cosine_q30(longint unsigned i, longint unsigned len);
    longint unsigned ph, t, theta, x2, term;
    longint sum;
    bit neg;
    neg = 1'b0;
    ph = (i << 32) / len;
    if (ph >= (64'd1 << 31)) ph = (64'd1 << 32) - ph;
    if (ph > (64'd1 << 30)) begin
      t = (64'd1 << 31) - ph;
      neg = 1'b1;
    end else begin
      t = ph;
    end
    theta = (t * 64'd6746518852) >> 32;
    x2 = (theta * theta) >> 30;
    term = 64'd1 << 30;
    sum = 64'sd1 <<< 30;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
      if (k & 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    return neg ? -sum : sum;
  endfunction

  function automatic longint unsigned window_level(longint unsigned i,
                                                   longint unsigned len);
    longint c;
    c = cosine_q30(i, len);
    if (win_hamming) return longint'(54 * (64'sd1 <<< 30) - 46 * c);
    return longint'(50 * (64'sd1 <<< 30) - 50 * c);
  endfunction

  function automatic window_point_t window_point(logic [nw_pkg::IDX_W-1:0] idx);
    window_point_t p;
    longint unsigned len, wp, w, amp;
    len = (win_len > nw_pkg::MAX_LENGTH) ? nw_pkg::MAX_LENGTH : win_len;
    p.oidx = nw_pkg::OIDX_W'(idx + longint'(blk_offset) * len);
    p.amp = '0;
    p.err = 1'b0;
    if (idx >= len) begin
      p.err = 1'b1;
    end else begin
      wp = window_level(len / 2, len);
      if (wp == 0) begin
        p.err = 1'b1;
      end else begin
        w = window_level(idx, len);
        amp = (w * 32768 + wp / 2) / wp;
        if (amp > 32768) amp = 32768;
        p.amp = nw_pkg::AMP_W'(amp);
      end
    end
    return p;
  endfunction

  function automatic int unsigned effective_len();
    return (win_len > nw_pkg::MAX_LENGTH) ? nw_pkg::MAX_LENGTH : win_len;
  endfunction

  // receiver: randomly chosen stretches of steady ready and random stalls
  int unsigned stall_run = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run <= $urandom_range(20, 200);
      stall_mode <= $urandom_range(0, 3);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    window_point_t exp_pt;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected item: output_index %0d amplitude %0d range_error %0d",
               output_index, amplitude, range_error);
        mismatches++;
      end else begin
        exp_pt = pending_points.pop_front();
        points_checked++;
        if (range_error) range_errors_seen++;
        if (output_index !== exp_pt.oidx) begin
          $error("output_index: expected %0d, actual %0d", exp_pt.oidx, output_index);
          mismatches++;
        end
        if (amplitude !== exp_pt.amp) begin
          $error("amplitude: expected %0d, actual %0d", exp_pt.amp, amplitude);
          mismatches++;
        end
        if (range_error !== exp_pt.err) begin
          $error("range_error: expected %0d, actual %0d", exp_pt.err, range_error);
          mismatches++;
        end
      end
    end
  end

  task automatic send_sample(logic [nw_pkg::IDX_W-1:0] idx);
    in_valid <= 1'b1;
    sample_index <= idx;
    do @(posedge clk); while (!in_ready);
    pending_points.push_back(window_point(idx));
  endtask

  task automatic idle_sender(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_points();
    idle_sender(0);
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after its last write
  task automatic write_reg(logic [nw_pkg::CFG_IDX_W-1:0] ri, logic [nw_pkg::LEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (ri)
      nw_pkg::REG_WINDOW_TYPE:   win_hamming = val[0];
      nw_pkg::REG_WINDOW_LENGTH: win_len = val;
      nw_pkg::REG_BLOCK_OFFSET:  blk_offset = val;
      default: ;
    endcase
  endtask

  task automatic set_window(logic [15:0] typ, logic [15:0] len, logic [15:0] off);
    drain_points();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(nw_pkg::REG_WINDOW_TYPE, typ);
    write_reg(nw_pkg::REG_WINDOW_LENGTH, len);
    write_reg(nw_pkg::REG_BLOCK_OFFSET, off);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [nw_pkg::IDX_W-1:0] pick_index();
    int unsigned len;
    len = effective_len();
    case ($urandom_range(0, 15))
      0: return nw_pkg::IDX_W'($urandom);
      1: return (len == 0) ? nw_pkg::IDX_W'(0) : nw_pkg::IDX_W'(len - 1);
      2: return nw_pkg::IDX_W'(len);
      3: return nw_pkg::IDX_W'(len / 2);
      default: return (len == 0) ? nw_pkg::IDX_W'($urandom)
                                 : nw_pkg::IDX_W'($urandom_range(0, len - 1));
    endcase
  endfunction

  task automatic random_phase(int unsigned n_items, bit mid_pause);
    int unsigned sent, burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        send_sample(pick_index());
        sent++;
        if (mid_pause && sent == n_items / 2) drain_points();
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  directed_row_t directed[] = '{
    '{15'd0,     1'b1, 16'd0,     1'b0},
    '{15'd256,   1'b1, 16'd32768, 1'b0},
    '{15'd512,   1'b1, 16'd0,     1'b1},
    '{15'd32767, 1'b1, 16'd0,     1'b1},
    '{15'd511,   1'b0, 16'd0,     1'b0},
    '{15'd1,     1'b0, 16'd0,     1'b0},
    '{15'd128,   1'b0, 16'd0,     1'b0},
    '{15'd384,   1'b0, 16'd0,     1'b0},
    '{15'd255,   1'b0, 16'd0,     1'b0},
    '{15'd257,   1'b0, 16'd0,     1'b0},
    '{15'h2AAA,  1'b0, 16'd0,     1'b0},
    '{15'h5555,  1'b0, 16'd0,     1'b0}
  };

  initial begin
    window_point_t pt;
    win_hamming = 1'b0;
    win_len = nw_pkg::RST_LENGTH;
    blk_offset = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r]) begin
      send_sample(directed[r].idx);
      if (directed[r].known) begin
        pt = pending_points.pop_back();
        pt.amp = directed[r].amp;
        pt.err = directed[r].err;
        pending_points.push_back(pt);
      end
    end

    // extremes and special settings, then random ones
    set_window(16'd0, 16'd1, 16'd7);
    for (int i = 0; i < 3; i++) send_sample(nw_pkg::IDX_W'(i));
    set_window(16'd1, 16'd1, 16'd65535);
    for (int i = 0; i < 3; i++) send_sample(nw_pkg::IDX_W'(i));
    drain_points();
    write_reg(REG_SPARE, 16'hFFFF);
    cfg_valid <= 1'b0;
    set_window(16'hFFFE, 16'd0, 16'd3);
    send_sample(15'd0);
    send_sample(15'h7FFF);
    set_window(16'd1, 16'd32768, 16'd65535);
    random_phase(120, 1'b1);
    set_window(16'd0, 16'd65535, 16'd65535);
    random_phase(120, 1'b0);
    set_window(16'd1, 16'd2, 16'd0);
    random_phase(40, 1'b0);
    set_window(16'd0, 16'd3, 16'd1);
    random_phase(40, 1'b0);
    for (int ph = 0; ph < 14; ph++) begin
      set_window(16'($urandom), ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(1, 2048)),
                 16'($urandom));
      random_phase(115, 1'b0);
    end

    drain_points();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d window points checked over %0d register settings, %0d flagged",
             points_checked, settings_used, range_errors_seen);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
